[rtl/mbp_pkg.sv]
// Shared types and constants for the three-level MRU page buffer.
// No dependencies; mbp_front, mbp_lookup and the top level import this package.
`timescale 1ns / 1ps
package mbp_pkg;

	localparam int DP_W   = 20;          // data page / page count width
	localparam int PAGE_W = 21;          // buffered page number width
	localparam int SLOT_W = 4;           // slot field width on the result word
	localparam int LVL_W  = 2;

	// divide by 100 as multiply by reciprocal, exact for every 20-bit value
	localparam int                 DIV_C    = 100;
	localparam int                 RECIP_W  = 21;
	localparam logic [RECIP_W-1:0] RECIP_K  = RECIP_W'(1342178);
	localparam int                 RECIP_SH = 27;
	localparam int                 PROD_W   = DP_W + RECIP_W;
	localparam int                 QUOT_W   = 14;

	localparam logic [PAGE_W-1:0] ROOT_PAGE = PAGE_W'(1);

	localparam logic [LVL_W-1:0] LVL_ROOT  = 2'd0;
	localparam logic [LVL_W-1:0] LVL_INDEX = 2'd1;
	localparam logic [LVL_W-1:0] LVL_LEAF  = 2'd2;

	// configuration port
	localparam int          APB_AW  = 3;
	localparam int          APB_DW  = 32;
	localparam logic [0:0]  REG_DPC = 1'b0;   // data_page_count, word index

	typedef struct packed {
		logic [DP_W-1:0] data_page;
		logic            is_write;
	} req_t;

	typedef struct packed {
		logic [LVL_W-1:0]  level;
		logic [PAGE_W-1:0] page;
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              evicted;
		logic [PAGE_W-1:0] victim_page;
		logic              write_back;
		logic              last;
	} rsp_t;

	// pages of one request after the front has worked them out
	typedef struct packed {
		logic [PAGE_W-1:0] idx_page;
		logic [PAGE_W-1:0] leaf_page;
		logic              is_write;
	} job_t;

endpackage

[rtl/mbp_fifo.sv]
// Small register queue used between front and back and on the result side.
// Generic width and depth; no package use.
`timescale 1ns / 1ps
module mbp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[rtl/mbp_front.sv]
// Front end: takes a request word and works out its index and leaf pages.
// Uses mbp_pkg; feeds the job queue in front of mbp_lookup.
`timescale 1ns / 1ps
module mbp_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  mbp_pkg::req_t            req,
	input  logic [mbp_pkg::DP_W-1:0] data_page_count,
	output logic                     job_push,
	output mbp_pkg::job_t            job,
	input  logic                     job_full
);
	import mbp_pkg::*;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV  = 2'd1;
	localparam logic [1:0] F_FIN  = 2'd2;

	logic [1:0]        state_q;
	logic [DP_W-1:0]   dp_q;
	logic              wr_q;
	logic [QUOT_W-1:0] qdp_q, qcnt_q;
	logic [PROD_W-1:0] prod_dp, prod_cnt;
	logic [DP_W-1:0]   back_mul;
	logic              exact;

	assign full = (state_q != F_IDLE);

	assign prod_dp  = PROD_W'(dp_q) * PROD_W'(RECIP_K);
	assign prod_cnt = PROD_W'(data_page_count) * PROD_W'(RECIP_K);

	// page/100 rounded down times 100 equals page only on a multiple of 100
	assign back_mul = DP_W'(qdp_q) * DP_W'(DIV_C);
	assign exact    = (back_mul == dp_q);

	assign job_push       = (state_q == F_FIN) && !job_full;
	assign job.idx_page   = PAGE_W'(qdp_q) + (exact ? PAGE_W'(1) : PAGE_W'(2));
	assign job.leaf_page  = PAGE_W'(dp_q) + PAGE_W'(qcnt_q) + PAGE_W'(2);
	assign job.is_write   = wr_q;

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			dp_q <= req.data_page;
			wr_q <= req.is_write;
		end
		if (state_q == F_DIV) begin
			qdp_q  <= prod_dp[RECIP_SH +: QUOT_W];
			qcnt_q <= prod_cnt[RECIP_SH +: QUOT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: if (push) state_q <= F_DIV;
				F_DIV:  state_q <= F_FIN;
				F_FIN:  if (!job_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

[rtl/mbp_lookup.sv]
// Back end: slot store with tag compare, MRU victim search and age update.
// Uses mbp_pkg; runs root, index and leaf lookups of one job in turn.
`timescale 1ns / 1ps
module mbp_lookup #(
	parameter int SLOTS    = 16,
	parameter int AGE_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  mbp_pkg::job_t job,
	output logic          job_pop,
	input  logic          out_full,
	output logic          out_push,
	output mbp_pkg::rsp_t out_data
);
	import mbp_pkg::*;

	localparam int                  SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int                  NP      = 2 ** SW;
	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	logic [PAGE_W-1:0]   page_q  [SLOTS];
	logic [AGE_BITS-1:0] age_q   [SLOTS];
	logic [SLOTS-1:0]    valid_q;
	logic [SLOTS-1:0]    dirty_q;
	logic [LVL_W-1:0]    lvl_q;

	logic                step;
	logic [PAGE_W-1:0]   pg;
	logic [SLOTS-1:0]    match;
	logic                found, any_empty, evict;
	logic [SW-1:0]       found_idx, empty_idx, sel;
	logic [SW+SLOT_W-1:0] sel_ext;

	// min-age tree, node 1 is the root, leaves at NP..2*NP-1
	logic                node_ok  [2*NP];
	logic [AGE_BITS-1:0] node_age [2*NP];
	logic [SW-1:0]       node_idx [2*NP];

	assign step    = job_valid && !out_full;
	assign job_pop = step && (lvl_q == LVL_LEAF);

	always_comb begin
		case (lvl_q)
			LVL_ROOT:  pg = ROOT_PAGE;
			LVL_INDEX: pg = job.idx_page;
			LVL_LEAF:  pg = job.leaf_page;
			default:   pg = ROOT_PAGE;
		endcase
	end

	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		any_empty = 1'b0;
		empty_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = valid_q[i] && (page_q[i] == pg);
			// highest index wins for both
			if (match[i]) begin
				found     = 1'b1;
				found_idx = SW'(i);
			end
			if (!valid_q[i]) begin
				any_empty = 1'b1;
				empty_idx = SW'(i);
			end
		end
	end

	// lowest age, lowest index on a tie: left child wins when ages are equal
	always_comb begin
		for (int i = 0; i < NP; i++) begin
			node_ok[NP+i]  = (i < SLOTS);
			node_age[NP+i] = (i < SLOTS) ? age_q[(i < SLOTS) ? i : 0] : '0;
			node_idx[NP+i] = SW'(i);
		end
		node_ok[0]  = 1'b0;
		node_age[0] = '0;
		node_idx[0] = '0;
		for (int n = NP - 1; n >= 1; n--) begin
			if (node_ok[2*n] && (!node_ok[2*n+1] || node_age[2*n] <= node_age[2*n+1])) begin
				node_ok[n]  = node_ok[2*n];
				node_age[n] = node_age[2*n];
				node_idx[n] = node_idx[2*n];
			end else begin
				node_ok[n]  = node_ok[2*n+1];
				node_age[n] = node_age[2*n+1];
				node_idx[n] = node_idx[2*n+1];
			end
		end
	end

	assign evict   = !found && !any_empty;
	assign sel     = found ? found_idx : (any_empty ? empty_idx : node_idx[1]);
	assign sel_ext = (SW+SLOT_W)'(sel);

	assign out_push             = step;
	assign out_data.level       = lvl_q;
	assign out_data.page        = pg;
	assign out_data.hit         = found;
	assign out_data.slot        = sel_ext[SLOT_W-1:0];
	assign out_data.evicted     = evict;
	assign out_data.victim_page = evict ? page_q[node_idx[1]] : '0;
	assign out_data.write_back  = evict && dirty_q[node_idx[1]];
	assign out_data.last        = (lvl_q == LVL_LEAF);

	always_ff @(posedge clk) begin
		if (step && !found) begin
			page_q[sel] <= pg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			lvl_q   <= LVL_ROOT;
			for (int i = 0; i < SLOTS; i++) begin
				age_q[i] <= '0;
			end
		end else if (step) begin
			case (lvl_q)
				LVL_ROOT:  lvl_q <= LVL_INDEX;
				LVL_INDEX: lvl_q <= LVL_LEAF;
				default:   lvl_q <= LVL_ROOT;
			endcase
			for (int i = 0; i < SLOTS; i++) begin
				if (SW'(i) == sel) begin
					// cleared on use, then aged with the rest
					valid_q[i] <= 1'b1;
					age_q[i]   <= AGE_BITS'(1);
					dirty_q[i] <= found ? (dirty_q[i] | job.is_write) : job.is_write;
				end else if (valid_q[i] && age_q[i] != AGE_MAX) begin
					age_q[i] <= age_q[i] + AGE_BITS'(1);
				end
			end
		end
	end

endmodule

[rtl/mru_buffer_pool_three_level.sv]
// Three-level MRU page buffer: front, job queue, lookup unit, result queue.
// A request passes the front (capture, divide, hand-over), the job queue, then the
// lookup unit, whose root, index and leaf lookups of the slot store run one per cycle
// while the result queue is not full; the front takes a new request once idle.
// Reset: all slots empty, ages and dirty bits clear, data_page_count 0.
// Uses mbp_pkg, mbp_fifo, mbp_front, mbp_lookup.
`timescale 1ns / 1ps
module mru_buffer_pool_three_level #(
	parameter int SLOTS    = 16,
	parameter int AGE_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  mbp_pkg::req_t              req,
	output logic                       empty,
	input  logic                       pop,
	output mbp_pkg::rsp_t              res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mbp_pkg::APB_AW-1:0] paddr,
	input  logic [mbp_pkg::APB_DW-1:0] pwdata,
	output logic [mbp_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import mbp_pkg::*;

	localparam int JOB_W = $bits(job_t);
	localparam int RSP_W = $bits(rsp_t);

	logic [DP_W-1:0] dpc_q;
	logic            cfg_wr, reg_hit;

	logic            job_push, job_full, job_empty, job_pop;
	job_t            job_in, job_out;
	logic            out_push, out_full;
	rsp_t            out_data;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_AW-1:2] == REG_DPC);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? APB_DW'(dpc_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpc_q <= '0;
		end else if (cfg_wr) begin
			dpc_q <= pwdata[DP_W-1:0];
		end
	end

	mbp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.req             (req),
		.data_page_count (dpc_q),
		.job_push        (job_push),
		.job             (job_in),
		.job_full        (job_full)
	);

	mbp_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (2)
	) u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_in),
		.rd_en   (job_pop),
		.rd_data (job_out),
		.full    (job_full),
		.empty   (job_empty)
	);

	mbp_lookup #(
		.SLOTS    (SLOTS),
		.AGE_BITS (AGE_BITS)
	) u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_data  (out_data)
	);

	mbp_fifo #(
		.WIDTH (RSP_W),
		.DEPTH (2)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_data),
		.rd_en   (pop),
		.rd_data (res),
		.full    (out_full),
		.empty   (empty)
	);

endmodule

[test/tb.sv]
// Self-checking bench for mru_buffer_pool_three_level: queue handshake on both sides,
// APB register writes between phases, and an MRU buffer predictor for every word.
// Depends on rtl/mbp_pkg.sv, the top level and the RTL below it.
`timescale 1ns / 1ps
module tb;
	import mbp_pkg::*;

	localparam int SLOTS      = 16;
	localparam int AGE_BITS   = 16;
	localparam logic [AGE_BITS-1:0] AGE_TOP = '1;
	localparam int LIMIT      = 1000000;
	localparam int DRAIN_GAP  = 12;
	localparam int RAND_ITEMS = 28;
	localparam int HOLD_ITEMS = 20;
	localparam int HOLD_LEN   = 600;
	localparam int TYPED_ROWS = 4;
	localparam int DIR_ROWS   = 19;
	localparam logic [APB_AW-1:0] DPC_ADDR = APB_AW'(4 * int'(REG_DPC));

	// directed requests, {data_page, is_write}
	localparam logic [DP_W:0] DIR_LIST [DIR_ROWS] = '{
		{20'd0, 1'b0}, {20'd0, 1'b1}, {20'd100, 1'b0}, {20'd1048575, 1'b1},
		{20'd99, 1'b0}, {20'd101, 1'b1}, {20'd1048500, 1'b1}, {20'd5000, 1'b1},
		{20'd6000, 1'b0}, {20'd7000, 1'b1}, {20'd8000, 1'b1}, {20'd8000, 1'b0},
		{20'd1, 1'b0}, {20'd200, 1'b1}, {20'd1048575, 1'b0}, {20'd0, 1'b0},
		{20'd300, 1'b0}, {20'd99, 1'b1}, {20'd400, 1'b1}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                push;
	logic                full;
	req_t                req;
	logic                empty;
	logic                pop;
	rsp_t                res;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	// buffer predictor state
	logic [PAGE_W-1:0]   buf_page [SLOTS];
	bit                  buf_valid [SLOTS];
	logic [AGE_BITS-1:0] buf_age [SLOTS];
	bit                  buf_dirty [SLOTS];
	logic [DP_W-1:0]     page_count;

	rsp_t                due_words [$];
	rsp_t                typed_words [TYPED_ROWS*3];
	logic [DP_W-1:0]     recent [8];

	int send_idle_pct, stall_pct;
	bit hold_ask;
	int hold_left;
	int cycles, errors, requests, words, hits, evictions, write_backs, full_waits;

	mru_buffer_pool_three_level dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles, %0d words outstanding", cycles,
				due_words.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic string fmt(input rsp_t w);
		return $sformatf("lvl=%0d page=%0d hit=%0b slot=%0d ev=%0b victim=%0d wb=%0b last=%0b",
			w.level, w.page, w.hit, w.slot, w.evicted, w.victim_page, w.write_back,
			w.last);
	endfunction

	function automatic rsp_t word_of(input logic [LVL_W-1:0] lv, input int pg, input bit h,
			input int sl, input bit lst);
		rsp_t w;
		w = '0;
		w.level = lv;
		w.page  = PAGE_W'(pg);
		w.hit   = h;
		w.slot  = SLOT_W'(sl);
		w.last  = lst;
		return w;
	endfunction

	function automatic rsp_t buf_lookup(input logic [PAGE_W-1:0] pg, input bit wr,
			input logic [LVL_W-1:0] lv, input bit lst);
		int found, vacant, s;
		rsp_t w;
		found  = -1;
		vacant = -1;
		w = '0;
		// highest index wins for both the match and the empty slot
		for (int i = 0; i < SLOTS; i++) begin
			if (buf_valid[i] && buf_page[i] == pg)
				found = i;
			if (!buf_valid[i])
				vacant = i;
		end
		if (found >= 0) begin
			s = found;
			buf_age[s] = '0;
			if (wr)
				buf_dirty[s] = 1'b1;
		end else begin
			if (vacant >= 0)
				s = vacant;
			else begin
				// youngest goes, lowest index on a tie
				s = 0;
				for (int i = 1; i < SLOTS; i++)
					if (buf_age[i] < buf_age[s])
						s = i;
				w.evicted     = 1'b1;
				w.victim_page = buf_page[s];
				w.write_back  = buf_dirty[s];
			end
			buf_page[s]  = pg;
			buf_valid[s] = 1'b1;
			buf_age[s]   = '0;
			buf_dirty[s] = wr;
		end
		for (int i = 0; i < SLOTS; i++)
			if (buf_valid[i] && buf_age[i] != AGE_TOP)
				buf_age[i]++;
		w.level = lv;
		w.page  = pg;
		w.hit   = (found >= 0);
		w.slot  = SLOT_W'(s);
		w.last  = lst;
		return w;
	endfunction

	function automatic void run_request(input req_t r, output rsp_t w[3]);
		logic [PAGE_W-1:0] ix, lf;
		if (r.data_page % DIV_C == 0)
			ix = PAGE_W'(r.data_page / DIV_C) + PAGE_W'(1);
		else
			ix = PAGE_W'(r.data_page / DIV_C) + PAGE_W'(2);
		lf = PAGE_W'(r.data_page) + PAGE_W'(page_count / DIV_C) + PAGE_W'(2);
		w[0] = buf_lookup(ROOT_PAGE, r.is_write, LVL_ROOT, 1'b0);
		w[1] = buf_lookup(ix, r.is_write, LVL_INDEX, 1'b0);
		w[2] = buf_lookup(lf, r.is_write, LVL_LEAF, 1'b1);
	endfunction

	task automatic report(input string why, input rsp_t want, input rsp_t got);
		errors++;
		if (errors <= 10)
			$display("%s at cycle %0d\n  expected %s\n  actual   %s", why, cycles,
				fmt(want), fmt(got));
	endtask

	// monitor and pop driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				words++;
				hits        += res.hit;
				evictions   += res.evicted;
				write_backs += res.write_back;
				if (due_words.size() == 0)
					report("Word with nothing expected", '0, res);
				else if (res !== due_words[0]) begin
					report("Word mismatch", due_words[0], res);
					void'(due_words.pop_front());
				end else
					void'(due_words.pop_front());
			end
			if (hold_ask) begin
				hold_ask  = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else
				pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic put_req(input req_t r, input int typed_row);
		rsp_t w[3];
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		push <= 1'b1;
		req  <= r;
		@(posedge clk);
		while (full) begin
			full_waits++;
			@(posedge clk);
		end
		requests++;
		run_request(r, w);
		for (int k = 0; k < 3; k++)
			due_words.push_back(typed_row >= 0 ? typed_words[3*typed_row+k] : w[k]);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		page_count = val[DP_W-1:0];
	endtask

	// mix of reused pages (hits), round hundreds, small pages, the full range and both ends
	function automatic req_t rand_req();
		req_t r;
		int sel;
		sel = $urandom_range(99);
		if (sel < 40)
			r.data_page = recent[$urandom_range(7)];
		else if (sel < 55)
			r.data_page = DP_W'(DIV_C * $urandom_range(0, 10485));
		else if (sel < 82)
			r.data_page = DP_W'($urandom_range(0, 3000));
		else if (sel < 94)
			r.data_page = DP_W'($urandom);
		else if (sel < 97)
			r.data_page = '1;
		else
			r.data_page = '0;
		r.is_write = 1'($urandom_range(1));
		recent[$urandom_range(7)] = r.data_page;
		return r;
	endfunction

	initial begin
		int cfg_val [4];
		int idle_set [4];
		int stall_set [4];
		arst_n  <= 1'b0;
		push    <= 1'b0;
		req     <= '0;
		pop     <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		for (int i = 0; i < SLOTS; i++) begin
			buf_page[i]  = '0;
			buf_valid[i] = 1'b0;
			buf_age[i]   = '0;
			buf_dirty[i] = 1'b0;
		end
		for (int i = 0; i < 8; i++)
			recent[i] = '0;
		page_count = '0;
		typed_words = '{
			word_of(LVL_ROOT, 1, 0, 15, 0), word_of(LVL_INDEX, 1, 1, 15, 0),
			word_of(LVL_LEAF, 2, 0, 14, 1),
			word_of(LVL_ROOT, 1, 1, 15, 0), word_of(LVL_INDEX, 1, 1, 15, 0),
			word_of(LVL_LEAF, 2, 1, 14, 1),
			word_of(LVL_ROOT, 1, 1, 15, 0), word_of(LVL_INDEX, 2, 1, 14, 0),
			word_of(LVL_LEAF, 102, 0, 13, 1),
			word_of(LVL_ROOT, 1, 1, 15, 0), word_of(LVL_INDEX, 10487, 0, 12, 0),
			word_of(LVL_LEAF, 1048577, 0, 11, 1)
		};
		cfg_val   = '{1048575, 99, 100, 0};
		idle_set  = '{0, 63, 0, 18};
		stall_set = '{0, 0, 63, 18};
		cfg_val[3] = $urandom_range(0, 1048575);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: page count at its reset value, buffer fills then evicts
		for (int i = 0; i < DIR_ROWS; i++)
			put_req(req_t'(DIR_LIST[i]), i < TYPED_ROWS ? i : -1);
		drain();

		for (int p = 0; p < 4; p++) begin
			reg_write(DPC_ADDR, APB_DW'(cfg_val[p]));
			send_idle_pct = idle_set[p];
			stall_pct     = stall_set[p];
			for (int i = 0; i < RAND_ITEMS; i++)
				put_req(rand_req(), -1);
			drain();
		end

		// long receiver hold-off: input must back up behind full
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_ask      = 1'b1;
		for (int i = 0; i < HOLD_ITEMS; i++)
			put_req(rand_req(), -1);
		drain();

		reg_write(DPC_ADDR, '0);
		send_idle_pct = 18;
		stall_pct     = 18;
		for (int i = 0; i < 20; i++)
			put_req(rand_req(), -1);
		drain();

		if (due_words.size() != 0) begin
			errors++;
			$display("%0d expected words never arrived", due_words.size());
		end
		$display("Ran %0d requests over four idle mixes and a long hold-off; %0d words: %0d hits,",
			requests, words, hits);
		$display("%0d evictions, %0d write-backs; input held off by full for %0d cycles",
			evictions, write_backs, full_waits);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
